>>> design/ge2e_pkg.sv
`default_nettype none
package ge2e_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 23;
  localparam int CORDIC_STAGES_DEF = 24;

  // latency of the radius datapath, input to registered output
  localparam int RAD_LATENCY = 36;

  localparam logic signed [63:0] SEMI_MAJOR_MM = 64'sd6378137000;
  localparam logic signed [63:0] ECC2_Q40 = 64'sd7360548629;
  localparam logic signed [63:0] POLAR2_Q40 = 64'sd1092151079147;
  localparam logic signed [63:0] ONE_Q60 = 64'sd1152921504606846976;
  localparam logic signed [63:0] THREE_Q60 = 64'sd3458764513820540928;
  localparam logic signed [31:0] CORDIC_INV_GAIN_Q30 = 32'sd652032874;

  // floor(v / 45) == (v * DIV45_MAGIC) >> 38 for every 32-bit v
  localparam logic [32:0] DIV45_MAGIC = 33'd6108397933;

  function automatic logic signed [31:0] atan_turn(input int idx);
    logic signed [31:0] r;
    case (idx)
      0: r = 32'sd536870912;
      1: r = 32'sd316933406;
      2: r = 32'sd167458907;
      3: r = 32'sd85004756;
      4: r = 32'sd42667331;
      5: r = 32'sd21354465;
      6: r = 32'sd10679838;
      7: r = 32'sd5340245;
      8: r = 32'sd2670163;
      9: r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      20: r = 32'sd652;
      21: r = 32'sd326;
      22: r = 32'sd163;
      23: r = 32'sd81;
      24: r = 32'sd41;
      25: r = 32'sd20;
      26: r = 32'sd10;
      27: r = 32'sd5;
      28: r = 32'sd3;
      29: r = 32'sd1;
      30: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/ge2e_delay.sv
`default_nettype none
module ge2e_delay #(
  parameter int W = 64,
  parameter int N = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[N-1];

endmodule
`default_nettype wire

>>> design/ge2e_mul.sv
`default_nettype none
module ge2e_mul #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] p00;
  logic [63:0] p01;
  logic [63:0] p10;
  logic [63:0] p11;
  logic        neg1;
  logic [127:0] sum;
  logic [63:0] r2;
  logic        neg2;

  assign ua = a;
  assign ub = b;
  assign ma = ua[63] ? (~ua + 64'd1) : ua;
  assign mb = ub[63] ? (~ub + 64'd1) : ub;

  // partial products on 32-bit halves
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= 64'(ma[31:0]) * 64'(mb[31:0]);
      p01 <= 64'(ma[31:0]) * 64'(mb[63:32]);
      p10 <= 64'(ma[63:32]) * 64'(mb[31:0]);
      p11 <= 64'(ma[63:32]) * 64'(mb[63:32]);
      neg1 <= ua[63] ^ ub[63];
    end
  end

  assign sum = 128'(p00) + (128'(p01) << 32) + (128'(p10) << 32) + (128'(p11) << 64);

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= sum[SHIFT+63:SHIFT];
      neg2 <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg2 ? -$signed(r2) : $signed(r2);
    end
  end

endmodule
`default_nettype wire

>>> design/ge2e_sincos.sv
`default_nettype none
module ge2e_sincos #(
  parameter int ANGLE_W = 32,
  parameter int FRAC_BITS = ge2e_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int STAGES = ge2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic signed [31:0]       sin_q30,
  output logic signed [31:0]       cos_q30
);
  import ge2e_pkg::*;

  localparam int SH3 = 29 - FRAC_BITS;
  localparam int TW = 6 + SH3 + 1;
  localparam int PW = TW + 33;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // degrees to turns: (mag * 2^(32-F) + 180) / 360 as two divides by 45
  logic [ANGLE_W-1:0] araw;
  logic [ANGLE_W-1:0] nmag;
  logic [31:0] mag;
  logic [64:0] p1;
  logic [31:0] s1_mag;
  logic [26:0] s1_q1;
  logic        s1_neg;

  assign araw = angle;
  assign nmag = araw[ANGLE_W-1] ? (~araw + 1'b1) : araw;
  assign mag = 32'(nmag);
  assign p1 = 65'(mag) * 65'(DIV45_MAGIC);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag <= mag;
      s1_q1 <= p1[64:38];
      s1_neg <= araw[ANGLE_W-1];
    end
  end

  logic [31:0]   prod45;
  logic [31:0]   rem45;
  logic [TW-1:0] t_next;
  logic [26:0]   s2_q1;
  logic [TW-1:0] s2_t;
  logic          s2_neg;

  assign prod45 = 32'(s1_q1) * 32'd45;
  assign rem45 = s1_mag - prod45;
  assign t_next = TW'({rem45[5:0], {SH3{1'b0}}}) + TW'(22);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q1 <= s1_q1;
      s2_t <= t_next;
      s2_neg <= s1_neg;
    end
  end

  logic [PW-1:0] p2;
  logic [63:0]   tmag;
  logic [31:0]   s3_phase;

  assign p2 = PW'(s2_t) * PW'(DIV45_MAGIC);
  assign tmag = (64'(s2_q1) << SH3) + 64'(p2[PW-1:38]);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_phase <= s2_neg ? (~tmag[31:0] + 32'd1) : tmag[31:0];
    end
  end

  // quadrant split, residual angle centered on zero
  logic [31:0]        shifted;
  logic signed [31:0] z0;

  assign shifted = s3_phase + 32'h2000_0000;
  assign z0 = $signed({2'b00, shifted[29:0]}) - 32'sd536870912;

  logic signed [31:0] cx [0:STAGES-1];
  logic signed [31:0] cy [0:STAGES-1];
  logic signed [31:0] cz [0:STAGES-1];
  logic [1:0]         cq [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [31:0] zi;
    logic [1:0]         qi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_INV_GAIN_Q30;
      assign yi = 32'sd0;
      assign zi = z0;
      assign qi = shifted[31:30];
    end else begin : g_next
      assign xi = cx[i-1];
      assign yi = cy[i-1];
      assign zi = cz[i-1];
      assign qi = cq[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[31]) begin
          cx[i] <= xi - (yi >>> i);
          cy[i] <= yi + (xi >>> i);
          cz[i] <= zi - atan_turn(i);
        end else begin
          cx[i] <= xi + (yi >>> i);
          cy[i] <= yi - (xi >>> i);
          cz[i] <= zi + atan_turn(i);
        end
        cq[i] <= qi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (cq[STAGES-1])
        QUAD_0: begin
          cos_q30 <= cx[STAGES-1];
          sin_q30 <= cy[STAGES-1];
        end
        QUAD_1: begin
          cos_q30 <= -cy[STAGES-1];
          sin_q30 <= cx[STAGES-1];
        end
        QUAD_2: begin
          cos_q30 <= -cx[STAGES-1];
          sin_q30 <= -cy[STAGES-1];
        end
        default: begin
          cos_q30 <= cy[STAGES-1];
          sin_q30 <= -cx[STAGES-1];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/ge2e_radius.sv
`default_nettype none
module ge2e_radius (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] slat,
  input  logic signed [27:0] h,
  output logic signed [63:0] rn,
  output logic signed [63:0] rs
);
  import ge2e_pkg::*;

  localparam int H_DELAY = RAD_LATENCY - 1;

  logic [31:0] uslat;
  logic [31:0] ms;
  logic [63:0] sq;
  logic [33:0] sin2;

  assign uslat = slat;
  assign ms = uslat[31] ? (~uslat + 32'd1) : uslat;
  assign sq = 64'(ms) * 64'(ms);

  always_ff @(posedge clk) begin
    if (en) begin
      sin2 <= sq[63:30];
    end
  end

  logic [66:0] pu;
  logic [53:0] u;
  logic signed [63:0] inv_s [0:3];
  logic signed [63:0] den_s [0:2];
  logic signed [63:0] den0;
  logic signed [63:0] inv0;

  assign pu = 67'(sin2) * 67'(ECC2_Q40);
  assign u = pu[63:10];

  // newton start at 1 + u/2, denominator 1 - u
  always_ff @(posedge clk) begin
    if (en) begin
      den0 <= ONE_Q60 - $signed(64'(u));
      inv0 <= ONE_Q60 + $signed(64'(u[53:1]));
    end
  end

  assign inv_s[0] = inv0;
  assign den_s[0] = den0;

  for (genvar k = 0; k < 3; k++) begin : g_newton
    logic signed [63:0] y2;
    logic signed [63:0] dy2;
    logic signed [63:0] den3;
    logic signed [63:0] inv3;
    logic signed [63:0] inv6;
    logic signed [63:0] corr;

    ge2e_mul #(.SHIFT(60)) u_sq (.clk, .en, .a(inv_s[k]), .b(inv_s[k]), .p(y2));
    ge2e_delay #(.W(64), .N(3)) u_den3 (.clk, .en, .din(den_s[k]), .dout(den3));
    ge2e_delay #(.W(64), .N(3)) u_inv3 (.clk, .en, .din(inv_s[k]), .dout(inv3));
    ge2e_mul #(.SHIFT(60)) u_dy (.clk, .en, .a(den3), .b(y2), .p(dy2));
    ge2e_delay #(.W(64), .N(3)) u_inv6 (.clk, .en, .din(inv3), .dout(inv6));

    assign corr = THREE_Q60 - dy2;

    ge2e_mul #(.SHIFT(61)) u_upd (.clk, .en, .a(inv6), .b(corr), .p(inv_s[k+1]));

    if (k < 2) begin : g_den
      ge2e_delay #(.W(64), .N(6)) u_den9 (.clk, .en, .din(den3), .dout(den_s[k+1]));
    end
  end

  logic signed [63:0] n_q20;
  logic signed [63:0] ns_q20;
  logic signed [63:0] n_d3;
  logic [27:0]        hd;
  logic signed [63:0] h_q20;

  ge2e_mul #(.SHIFT(40)) u_n (.clk, .en, .a(SEMI_MAJOR_MM), .b(inv_s[3]), .p(n_q20));
  ge2e_mul #(.SHIFT(40)) u_ns (.clk, .en, .a(n_q20), .b(POLAR2_Q40), .p(ns_q20));
  ge2e_delay #(.W(64), .N(3)) u_nd (.clk, .en, .din(n_q20), .dout(n_d3));
  ge2e_delay #(.W(28), .N(H_DELAY)) u_hd (.clk, .en, .din(h), .dout(hd));

  assign h_q20 = $signed({{16{hd[27]}}, hd, 20'd0});

  always_ff @(posedge clk) begin
    if (en) begin
      rn <= n_d3 + h_q20;
      rs <= ns_q20 + h_q20;
    end
  end

endmodule
`default_nettype wire

>>> design/geodetic_to_ecef_unit.sv
`default_nettype none
// channel  signals                                      role
// fix      fix_valid fix_ready lat_angle lon_angle       geodetic word in
//          height_mm height_valid
// ecef     ecef_valid ecef_ready x_mm y_mm z_mm          ecef word out
//
// one word per cycle while the output is not stalled; the latency is set by the
// cordic stages, three newton steps and the multiplier chain
// the whole pipeline advances when the output register is empty or taken
// a stall freezes every stage, nothing is dropped or repeated
// synchronous reset clears the valid bits only
module geodetic_to_ecef_unit #(
  parameter int ANGLE_FRAC_BITS = ge2e_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = ge2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fix_valid,
  output logic               fix_ready,
  input  logic signed [30:0] lat_angle,
  input  logic signed [31:0] lon_angle,
  input  logic signed [27:0] height_mm,
  input  logic               height_valid,
  output logic               ecef_valid,
  input  logic               ecef_ready,
  output logic signed [33:0] x_mm,
  output logic signed [33:0] y_mm,
  output logic signed [33:0] z_mm
);
  import ge2e_pkg::*;

  localparam int L_SC = CORDIC_STAGES + 4;
  localparam int L_TOT = L_SC + RAD_LATENCY + 7;

  logic             en;
  logic [L_TOT-1:0] vld;

  assign en = !vld[L_TOT-1] || ecef_ready;
  assign fix_ready = en;
  assign ecef_valid = vld[L_TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L_TOT-2:0], fix_valid};
    end
  end

  logic signed [31:0] slat;
  logic signed [31:0] clat;
  logic signed [31:0] slon;
  logic signed [31:0] clon;
  logic signed [27:0] h_eff;
  logic [27:0]        h_d;

  assign h_eff = height_valid ? height_mm : 28'sd0;

  ge2e_sincos #(.ANGLE_W(31), .FRAC_BITS(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES))
    u_lat (.clk, .en, .angle(lat_angle), .sin_q30(slat), .cos_q30(clat));
  ge2e_sincos #(.ANGLE_W(32), .FRAC_BITS(ANGLE_FRAC_BITS), .STAGES(CORDIC_STAGES))
    u_lon (.clk, .en, .angle(lon_angle), .sin_q30(slon), .cos_q30(clon));
  ge2e_delay #(.W(28), .N(L_SC)) u_hd (.clk, .en, .din(h_eff), .dout(h_d));

  logic signed [63:0] rn;
  logic signed [63:0] rs;

  ge2e_radius u_rad (.clk, .en, .slat, .h(h_d), .rn, .rs);

  logic [31:0] clat_d;
  logic [31:0] slat_d;
  logic [31:0] clon_d;
  logic [31:0] slon_d;

  ge2e_delay #(.W(32), .N(RAD_LATENCY)) u_clat (.clk, .en, .din(clat), .dout(clat_d));
  ge2e_delay #(.W(32), .N(RAD_LATENCY)) u_slat (.clk, .en, .din(slat), .dout(slat_d));
  ge2e_delay #(.W(32), .N(RAD_LATENCY + 3)) u_clon (.clk, .en, .din(clon), .dout(clon_d));
  ge2e_delay #(.W(32), .N(RAD_LATENCY + 3)) u_slon (.clk, .en, .din(slon), .dout(slon_d));

  logic signed [63:0] t_q20;
  logic signed [63:0] zp;
  logic [63:0]        zp_d;
  logic signed [63:0] xp;
  logic signed [63:0] yp;

  ge2e_mul #(.SHIFT(30)) u_t (.clk, .en, .a(rn),
    .b($signed({{32{clat_d[31]}}, clat_d})), .p(t_q20));
  ge2e_mul #(.SHIFT(30)) u_z (.clk, .en, .a(rs),
    .b($signed({{32{slat_d[31]}}, slat_d})), .p(zp));
  ge2e_delay #(.W(64), .N(3)) u_zd (.clk, .en, .din(zp), .dout(zp_d));
  ge2e_mul #(.SHIFT(30)) u_x (.clk, .en, .a(t_q20),
    .b($signed({{32{clon_d[31]}}, clon_d})), .p(xp));
  ge2e_mul #(.SHIFT(30)) u_y (.clk, .en, .a(t_q20),
    .b($signed({{32{slon_d[31]}}, slon_d})), .p(yp));

  // q20 to mm, half away from zero
  function automatic logic [33:0] round_mm(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + 64'd524288) >> 20;
    return v[63] ? (~r[33:0] + 34'd1) : r[33:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      x_mm <= round_mm(xp);
      y_mm <= round_mm(yp);
      z_mm <= round_mm(zp_d);
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !ecef_valid)
    else $error("output word valid right after reset");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (ecef_valid && !ecef_ready) |=> $stable(vld))
    else $error("pipeline moved during output stall");
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !fix_ready |-> (ecef_valid && !ecef_ready))
    else $error("input held off without an output stall");
`endif

endmodule
`default_nettype wire

>>> tb/sv/geodetic_to_ecef_unit_tb.sv
`timescale 1ns / 100ps
module geodetic_to_ecef_unit_tb;

  localparam int FRAC = ge2e_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STAGES = ge2e_pkg::CORDIC_STAGES_DEF;
  localparam int PIPE_LAT = STAGES + 4 + 36 + 7;

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [27:0] hgt;
    logic               hval;
  } fix_word_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } ecef_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic fix_valid = 1'b0;
  logic fix_ready;
  logic signed [30:0] lat_angle = '0;
  logic signed [31:0] lon_angle = '0;
  logic signed [27:0] height_mm = '0;
  logic height_valid = 1'b0;
  logic ecef_valid;
  logic ecef_ready = 1'b0;
  logic signed [33:0] x_mm, y_mm, z_mm;

  fix_word_t  fix_queue[$];
  ecef_word_t ecef_expected[$];
  int mismatches = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 86;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  geodetic_to_ecef_unit dut (
    .clk(clk), .rst(rst),
    .fix_valid(fix_valid), .fix_ready(fix_ready),
    .lat_angle(lat_angle), .lon_angle(lon_angle),
    .height_mm(height_mm), .height_valid(height_valid),
    .ecef_valid(ecef_valid), .ecef_ready(ecef_ready),
    .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] umag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    return 64'(p >> sh);
  endfunction

  function automatic logic signed [63:0] smulsh(logic signed [63:0] a,
                                                logic signed [63:0] b, int sh);
    logic [63:0] r;
    r = mulsh(umag(a), umag(b), sh);
    return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] deg_to_turns(logic signed [63:0] ang);
    logic [63:0] q;
    q = ((umag(ang) << (32 - FRAC)) + 64'd180) / 64'd360;
    q = ang < 0 ? -q : q;
    return q[31:0];
  endfunction

  function automatic logic signed [63:0] floor_sh(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  task automatic cordic_sin_cos(input logic [31:0] phase,
                                output logic signed [63:0] s,
                                output logic signed [63:0] c);
    logic [31:0] sh;
    logic [1:0] quad;
    logic signed [63:0] z, x, y, nx;
    sh = phase + 32'h2000_0000;
    quad = sh[31:30];
    z = $signed({34'd0, sh[29:0]}) - 64'sh2000_0000;
    x = 64'(ge2e_pkg::CORDIC_INV_GAIN_Q30);
    y = '0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - floor_sh(y, i);
        y = y + floor_sh(x, i);
        z = z - 64'(ge2e_pkg::atan_turn(i));
      end else begin
        nx = x + floor_sh(y, i);
        y = y - floor_sh(x, i);
        z = z + 64'(ge2e_pkg::atan_turn(i));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [33:0] to_mm(logic signed [63:0] v);
    logic [63:0] r;
    logic signed [63:0] sv;
    r = (umag(v) + (64'd1 << 19)) >> 20;
    sv = v < 0 ? -$signed(r) : $signed(r);
    return sv[33:0];
  endfunction

  task automatic predict_ecef(input fix_word_t f, output ecef_word_t e);
    logic signed [63:0] slat, clat, slon, clon, h, rn, rs, t, sq;
    logic [63:0] sin2, u, den, inv, y2, dy2, nq, nsq;
    h = f.hval ? 64'(f.hgt) : 64'sd0;
    cordic_sin_cos(deg_to_turns(64'(f.lat)), slat, clat);
    cordic_sin_cos(deg_to_turns(64'(f.lon)), slon, clon);
    sq = slat * slat;
    sin2 = $unsigned(sq) >> 30;
    u = (sin2 * ge2e_pkg::ECC2_Q40) >> 10;
    den = ge2e_pkg::ONE_Q60 - u;
    inv = ge2e_pkg::ONE_Q60 + (u >> 1);
    for (int k = 0; k < 3; k++) begin
      y2 = mulsh(inv, inv, 60);
      dy2 = mulsh(den, y2, 60);
      inv = mulsh(inv, ge2e_pkg::THREE_Q60 - dy2, 61);
    end
    nq = mulsh(ge2e_pkg::SEMI_MAJOR_MM, inv, 40);
    nsq = mulsh(nq, ge2e_pkg::POLAR2_Q40, 40);
    rn = $signed(nq) + h * 64'sd1048576;
    rs = $signed(nsq) + h * 64'sd1048576;
    t = smulsh(rn, clat, 30);
    e.x = to_mm(smulsh(t, clon, 30));
    e.y = to_mm(smulsh(t, slon, 30));
    e.z = to_mm(smulsh(rs, slat, 30));
  endtask

  function automatic fix_word_t random_fix();
    fix_word_t f;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      f.lat = 31'($urandom);
      f.lon = $urandom;
      f.hgt = 28'($urandom);
    end else begin
      f.lat = 31'($signed($urandom_range(0, 1509949440)) - 754974720);
      f.lon = 32'($signed($urandom) % 33'sd1509949441);
      f.hgt = 28'($signed($urandom_range(0, 110000000)) - 10000000);
    end
    f.hval = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic fix_word_t mk(int lat, int lon, int hgt, bit hv);
    fix_word_t f;
    f.lat = 31'(lat); f.lon = lon; f.hgt = 28'(hgt); f.hval = hv;
    return f;
  endfunction

  // driver
  always @(posedge clk) begin
    fix_word_t f;
    ecef_word_t e;
    if (!rst) begin
      if (fix_valid && fix_ready) begin
        predict_ecef({lat_angle, lon_angle, height_mm, height_valid}, e);
        ecef_expected.push_back(e);
      end
      if (!fix_valid || fix_ready) begin
        if (fix_queue.size() > 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          f = fix_queue.pop_front();
          fix_valid <= 1'b1;
          lat_angle <= f.lat;
          lon_angle <= f.lon;
          height_mm <= f.hgt;
          height_valid <= f.hval;
        end else begin
          fix_valid <= 1'b0;
        end
      end
      ecef_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    ecef_word_t e;
    if (!rst && ecef_valid && ecef_ready) begin
      if (ecef_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word x=%0d y=%0d z=%0d", x_mm, y_mm, z_mm);
      end else begin
        e = ecef_expected.pop_front();
        if (e.x !== x_mm || e.y !== y_mm || e.z !== z_mm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                     e.x, e.y, e.z, x_mm, y_mm, z_mm);
        end
      end
    end
  end

  task automatic wait_drained();
    while (fix_queue.size() > 0 || fix_valid || ecef_expected.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int lims[3];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    lims = '{754974720, -754974720, 0};
    // directed: poles, equator, date line, flag handling, out of range angles
    foreach (lims[i]) begin
      fix_queue.push_back(mk(lims[i], 1509949440, 100000000, 1));
      fix_queue.push_back(mk(lims[i], -1509949440, -10000000, 1));
      fix_queue.push_back(mk(lims[i], 0, 0, 0));
    end
    fix_queue.push_back(mk(0, 754974720, 5000, 1));
    fix_queue.push_back(mk(0, -754974720, 5000, 0));
    fix_queue.push_back(mk(32'h3fffffff, 32'h7fffffff, 28'h7ffffff, 1));
    fix_queue.push_back(mk(32'h40000000, 32'h80000000, 28'h8000000, 1));
    fix_queue.push_back(mk(32'h7fffffff, 32'hffffffff, 28'hfffffff, 1));
    fix_queue.push_back(mk(-1, 1, -1, 1));
    fix_queue.push_back(mk(377487360, 1132462080, 8848000, 1));
    fix_queue.push_back(mk(900000000, -2000000000, 123, 0));
    fix_queue.push_back(mk(-900000000, 2000000000, 28'h8000000, 0));
    for (int i = 0; i < 350; i++) fix_queue.push_back(random_fix());
    wait_drained();
    // hold the sender while the next batch is queued
    hold_sender = 1'b1;
    for (int i = 0; i < 350; i++) fix_queue.push_back(random_fix());
    @(posedge clk);
    hold_sender = 1'b0;
    send_idle_pct = 86;
    recv_idle_pct = 38;
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 350; i++) fix_queue.push_back(random_fix());
    wait_drained();
    repeat (PIPE_LAT + 20) @(posedge clk);
    stim_done = 1'b1;
    if (mismatches == 0 && ecef_expected.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4000000;
    if (!stim_done) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

>>> sim.f
design/ge2e_pkg.sv
design/ge2e_delay.sv
design/ge2e_mul.sv
design/ge2e_sincos.sv
design/ge2e_radius.sv
design/geodetic_to_ecef_unit.sv
tb/sv/geodetic_to_ecef_unit_tb.sv
